>>> sv/cdq_pkg.sv
`default_nettype none
package cdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int CAP_W     = 5;
	localparam int CAP_RESET = 16;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_REAR  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_REAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [VAL_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] popped_value;
		status_t                  status;
		logic                     now_full;
		logic                     now_empty;
	} rsp_t;

	// Per-cycle command broadcast along one chain of cells.
	typedef struct packed {
		logic             shift_up;
		logic             shift_down;
		logic             load_tail;
		logic [VAL_W-1:0] value;
	} cell_cmd_t;

endpackage
`default_nettype wire

>>> sv/circular_deque.sv
`default_nettype none
// Double-ended queue of up to DEPTH signed 32-bit entries, with a run-time
// capacity (1..DEPTH, written through the cfg channel and honored only while
// the deque is empty; zero is taken as one). Every request (push front, push
// rear, pop front, pop rear) yields exactly one response carrying the popped
// value (zero unless a pop succeeded), a status (done, rejected full,
// rejected empty) and the full and empty flags after the operation. The
// contents live twice, in two rows of shift cells: one row keeps the front
// entry in its first cell, the other keeps the rear entry there, so either
// end is read from a fixed cell. A request is taken every clock cycle and its
// response is registered in the output register; the only limit
// is that output register, which holds the request side off while a response
// waits under stall.
module circular_deque #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	output logic                    req_stall,
	input  wire  cdq_pkg::req_t     req,
	output logic                    rsp_valid,
	input  wire                     rsp_stall,
	output cdq_pkg::rsp_t           rsp,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [cdq_pkg::CAP_W-1:0] cfg_data
);
	import cdq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int CAP_RST_I = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
	localparam logic [CW-1:0] CAP_RST = CW'(CAP_RST_I);
	localparam logic [CW-1:0] ONE = CW'(1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    cap_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             is_full;
	logic             cnt_zero;
	logic [CW-1:0]    count_nxt;
	rsp_t             rsp_nxt;
	cell_cmd_t        front_cmd;
	cell_cmd_t        rear_cmd;
	logic [VAL_W-1:0] front_head;
	logic [VAL_W-1:0] rear_head;
	logic [31:0]      cfg_wide;
	logic [CW-1:0]    cap_new;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign cfg_ready = 1'b1;

	assign cnt_zero = (count_q == '0);
	assign is_full  = (count_q == cap_q);

	assign cfg_wide = 32'(cfg_data);
	always_comb begin
		priority if (cfg_wide == 32'd0) begin
			cap_new = ONE;
		end else if (int'(cfg_wide) > DEPTH) begin
			cap_new = CW'(DEPTH);
		end else begin
			cap_new = CW'(cfg_wide);
		end
	end

	always_comb begin
		front_cmd = '{shift_up: 1'b0, shift_down: 1'b0, load_tail: 1'b0,
			value: req.push_value};
		rear_cmd  = front_cmd;
		count_nxt = count_q;
		rsp_nxt.popped_value = '0;
		rsp_nxt.status       = ST_DONE;

		unique case (req.mode)
			MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
				if (is_full) begin
					rsp_nxt.status = ST_FULL;
				end else begin
					count_nxt = count_q + ONE;
					if (req.mode == MODE_PUSH_FRONT) begin
						front_cmd.shift_up  = accept;
						rear_cmd.load_tail  = accept;
					end else begin
						rear_cmd.shift_up   = accept;
						front_cmd.load_tail = accept;
					end
				end
			end
			MODE_POP_FRONT, MODE_POP_REAR: begin
				if (cnt_zero) begin
					rsp_nxt.status = ST_EMPTY;
				end else begin
					count_nxt = count_q - ONE;
					// The opposite row only loses its last entry through the count.
					if (req.mode == MODE_POP_FRONT) begin
						rsp_nxt.popped_value = front_head;
						front_cmd.shift_down = accept;
					end else begin
						rsp_nxt.popped_value = rear_head;
						rear_cmd.shift_down  = accept;
					end
				end
			end
			default: begin
				rsp_nxt.status = ST_DONE;
			end
		endcase

		rsp_nxt.now_full  = (count_nxt == cap_q);
		rsp_nxt.now_empty = (count_nxt == '0);
	end

	cdq_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_front_row (
		.clk   (clk),
		.cmd   (front_cmd),
		.count (count_q),
		.head  (front_head)
	);

	cdq_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_rear_row (
		.clk   (clk),
		.cmd   (rear_cmd),
		.count (count_q),
		.head  (rear_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			// A capacity write is ignored while the deque holds entries.
			if (cfg_valid && cfg_ready && cnt_zero) begin
				cap_q <= cap_new;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

>>> sv/cdq_cell.sv
`default_nettype none
module cdq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire                      clk,
	input  wire  cdq_pkg::cell_cmd_t cmd,
	input  wire  [CW-1:0]            count,
	input  wire  [cdq_pkg::VAL_W-1:0] from_lo,
	input  wire  [cdq_pkg::VAL_W-1:0] from_hi,
	output logic [cdq_pkg::VAL_W-1:0] data
);
	import cdq_pkg::*;

	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	logic [VAL_W-1:0] data_q;

	// Entries above the occupancy count hold stale data; they are never read.
	always_ff @(posedge clk) begin
		priority if (cmd.shift_up) begin
			data_q <= from_lo;
		end else if (cmd.shift_down) begin
			data_q <= from_hi;
		end else if (cmd.load_tail && count == MY_POS) begin
			data_q <= cmd.value;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

>>> sv/cdq_chain.sv
`default_nettype none
module cdq_chain #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire                       clk,
	input  wire  cdq_pkg::cell_cmd_t  cmd,
	input  wire  [CW-1:0]             count,
	output logic [cdq_pkg::VAL_W-1:0] head
);
	import cdq_pkg::*;

	logic [VAL_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;

		if (i == 0) begin : g_first
			assign lo = cmd.value;
		end else begin : g_mid
			assign lo = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign hi = cell_data[i];
		end else begin : g_inner
			assign hi = cell_data[i+1];
		end

		cdq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.count   (count),
			.from_lo (lo),
			.from_hi (hi),
			.data    (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule
`default_nettype wire
